### hw/rtl/imuf_pkg.sv
// imuf_pkg: shared types and constants for the imu serial frame parser
// used by imuf_front, imuf_queue, imuf_back and imu_uart_frame_parser
// no dependencies
package imuf_pkg;

    // frame byte codes
    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACC   = 8'h51;
    localparam logic [7:0] TYPE_RATE  = 8'h52;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // frame status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_ANGLE  = 2'd0;
    localparam t_status ST_RATE   = 2'd1;
    localparam t_status ST_OTHER  = 2'd2;
    localparam t_status ST_BADSUM = 2'd3;

    // frame geometry
    localparam int POS_BITS  = 4;
    localparam int PAY_BYTES = 6;
    localparam int N_AXES    = 3;

    // centidegree scaling: raw * 18000 / 32768
    localparam int CD_SCALE = 18000;
    localparam int CD_SHIFT = 15;
    localparam int PROD_W   = 31;

    // decoupling queue between parser and result stage
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // one classified byte as passed from parser to result stage
    typedef struct packed {
        logic                     done;
        t_status                  status;
        logic [N_AXES-1:0][15:0]  raw;
    } t_evt;

endpackage

### hw/rtl/imuf_front.sv
// imuf_front: byte-level frame parser, header hunt, type check, running sum
// classifies every byte into one t_evt; depends on imuf_pkg
module imuf_front #(
    parameter int FRAME_BYTES = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_rx_byte,
    input  logic          i_full,
    output logic          o_wr,
    output imuf_pkg::t_evt o_evt
);
    import imuf_pkg::*;

    localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(FRAME_BYTES - 1);

    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [7:0]          r_sum, n_sum;
    logic [7:0]          r_kind, n_kind;
    logic [7:0]          r_pay [PAY_BYTES];
    logic                accept;
    logic                good_type;

    assign accept    = i_push && !i_full;
    assign o_wr      = accept;
    assign good_type = (i_rx_byte == TYPE_ACC) || (i_rx_byte == TYPE_RATE) ||
                       (i_rx_byte == TYPE_ANGLE);

    // next parser state and classification of this byte
    always_comb begin
        // raw angles straight from the payload bytes, little endian
        for (int a = 0; a < N_AXES; a++) begin
            o_evt.raw[a] = {r_pay[2*a+1], r_pay[2*a]};
        end
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_kind       = r_kind;
        o_evt.done   = 1'b0;
        o_evt.status = ST_ANGLE;
        if (r_pos == '0) begin
            if (i_rx_byte == HDR_BYTE) begin
                n_sum = HDR_BYTE;
                n_pos = POS_BITS'(1);
            end
        end else if (r_pos == POS_BITS'(1)) begin
            if (good_type) begin
                n_kind = i_rx_byte;
                n_sum  = r_sum + i_rx_byte;
                n_pos  = POS_BITS'(2);
            end else if (i_rx_byte == HDR_BYTE) begin
                n_sum = HDR_BYTE;
                n_pos = POS_BITS'(1);
            end else begin
                n_pos = '0;
            end
        end else if (r_pos >= LAST_POS) begin
            o_evt.done = 1'b1;
            n_pos      = '0;
            if (r_sum != i_rx_byte) begin
                o_evt.status = ST_BADSUM;
            end else if (r_kind == TYPE_RATE) begin
                o_evt.status = ST_RATE;
            end else if (r_kind == TYPE_ANGLE) begin
                o_evt.status = ST_ANGLE;
            end else begin
                o_evt.status = ST_OTHER;
            end
        end else begin
            n_sum = r_sum + i_rx_byte;
            n_pos = r_pos + POS_BITS'(1);
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sum  <= '0;
            r_kind <= '0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_kind <= n_kind;
        end
    end

    // payload capture at frame offsets two to seven
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < PAY_BYTES; k++) begin
            if (accept && (r_pos == POS_BITS'(k + 2)) && (r_pos < LAST_POS)) begin
                r_pay[k] <= i_rx_byte;
            end
        end
    end

endmodule

### hw/rtl/imuf_queue.sv
// imuf_queue: short flip-flop queue of t_evt between parser and result stage
// depends on imuf_pkg
module imuf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  imuf_pkg::t_evt i_data,
    output logic           o_full,
    input  logic           i_rd,
    output logic           o_empty,
    output imuf_pkg::t_evt o_data
);
    import imuf_pkg::*;

    t_evt                 r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wp;
    logic [QPTR_BITS-1:0] r_rp;
    logic [QCNT_BITS-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_BITS'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + QPTR_BITS'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + QPTR_BITS'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + QCNT_BITS'(1);
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - QCNT_BITS'(1);
            end
        end
    end

endmodule

### hw/rtl/imuf_back.sv
// imuf_back: result stage, event counters, angle latch and centidegree scaling
// holds the result register seen on the output ports; depends on imuf_pkg
module imuf_back #(
    parameter int COUNT_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  imuf_pkg::t_evt        i_evt,
    output logic                  o_rd,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_done,
    output imuf_pkg::t_status     o_status,
    output logic [imuf_pkg::N_AXES-1:0][15:0] o_raw,
    output logic [imuf_pkg::N_AXES-1:0][15:0] o_cd,
    output logic [COUNT_BITS-1:0] o_total,
    output logic [COUNT_BITS-1:0] o_fail,
    output logic [COUNT_BITS-1:0] o_rate,
    output logic [COUNT_BITS-1:0] o_angle
);
    import imuf_pkg::*;

    logic                        r_valid;
    logic                        r_done;
    t_status                     r_status;
    logic [N_AXES-1:0][15:0]     r_raw;
    logic [N_AXES-1:0][15:0]     r_cd;
    logic [COUNT_BITS-1:0]       r_total;
    logic [COUNT_BITS-1:0]       r_fail;
    logic [COUNT_BITS-1:0]       r_rate;
    logic [COUNT_BITS-1:0]       r_angle;
    logic [N_AXES-1:0][15:0]     n_cd;
    logic                        latch;

    // raw * 18000 / 32768, rounded toward zero
    function automatic logic [15:0] f_centideg(input logic [15:0] raw);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] adj;
        prod = PROD_W'($signed(raw)) * PROD_W'(CD_SCALE);
        adj  = prod + (prod[PROD_W-1] ? PROD_W'((1 << CD_SHIFT) - 1) : PROD_W'(0));
        return adj[CD_SHIFT +: 16];
    endfunction

    // take the next event whenever the result register is free or leaving
    assign o_rd  = !i_empty && (!r_valid || i_pop);
    assign latch = i_evt.done && (i_evt.status == ST_ANGLE);

    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            n_cd[a] = f_centideg(i_evt.raw[a]);
        end
    end

    // result register and state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_done   <= 1'b0;
            r_status <= ST_ANGLE;
            r_raw    <= '0;
            r_cd     <= '0;
            r_total  <= '0;
            r_fail   <= '0;
            r_rate   <= '0;
            r_angle  <= '0;
        end else if (o_rd) begin
            r_valid  <= 1'b1;
            r_done   <= i_evt.done;
            r_status <= i_evt.status;
            r_total  <= r_total + COUNT_BITS'(1);
            if (i_evt.done && (i_evt.status == ST_BADSUM)) begin
                r_fail <= r_fail + COUNT_BITS'(1);
            end
            if (i_evt.done && (i_evt.status == ST_RATE)) begin
                r_rate <= r_rate + COUNT_BITS'(1);
            end
            if (latch) begin
                r_angle <= r_angle + COUNT_BITS'(1);
                r_raw   <= i_evt.raw;
                r_cd    <= n_cd;
            end
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_raw    = r_raw;
    assign o_cd     = r_cd;
    assign o_total  = r_total;
    assign o_fail   = r_fail;
    assign o_rate   = r_rate;
    assign o_angle  = r_angle;

endmodule

### hw/rtl/imu_uart_frame_parser.sv
// imu_uart_frame_parser: top level of the imu serial frame parser
// instantiates imuf_front, imuf_queue and imuf_back; depends on imuf_pkg
//
// Takes one received serial byte per transfer on the push/full side and
// gives exactly one result per byte on the empty/pop side, in order. The
// parser hunts for a 0x55 header, checks the type byte (0x51, 0x52, 0x53),
// keeps an 8-bit running sum and judges the last byte of each FRAME_BYTES
// long frame as checksum. A good angle frame latches roll, pitch and yaw and
// their centidegree values; counters wrap at COUNT_BITS and the ports show
// their low 32 bits. One byte is accepted every cycle while full is low; the
// parser writes each accepted byte's result into a four-entry queue, and the
// result register loads it from the queue once that register is free. full
// rises only when the queue is filled because results are not popped; the
// result register lets a new byte in while the previous result still waits.
module imu_uart_frame_parser #(
    parameter int FRAME_BYTES = 11,
    parameter int COUNT_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        o_frame_done,
    output logic [1:0]  o_frame_status,
    output logic signed [15:0] o_roll_sample,
    output logic signed [15:0] o_pitch_sample,
    output logic signed [15:0] o_yaw_sample,
    output logic signed [15:0] o_roll_centideg,
    output logic signed [15:0] o_pitch_centideg,
    output logic signed [15:0] o_yaw_centideg,
    output logic [31:0] o_total_bytes,
    output logic [31:0] o_checksum_failures,
    output logic [31:0] o_rate_frames,
    output logic [31:0] o_angle_frames
);
    import imuf_pkg::*;

    logic                    q_wr;
    logic                    q_rd;
    logic                    q_full;
    logic                    q_empty;
    t_evt                    q_in;
    t_evt                    q_out;
    logic                    res_valid;
    logic                    res_done;
    t_status                 res_status;
    logic [N_AXES-1:0][15:0] res_raw;
    logic [N_AXES-1:0][15:0] res_cd;
    logic [COUNT_BITS-1:0]   cnt_total;
    logic [COUNT_BITS-1:0]   cnt_fail;
    logic [COUNT_BITS-1:0]   cnt_rate;
    logic [COUNT_BITS-1:0]   cnt_angle;

    // parser front end
    imuf_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_rx_byte (i_rx_byte),
        .i_full    (q_full),
        .o_wr      (q_wr),
        .o_evt     (q_in)
    );

    // decoupling queue
    imuf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // result stage
    imuf_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_evt    (q_out),
        .o_rd     (q_rd),
        .i_pop    (pop),
        .o_valid  (res_valid),
        .o_done   (res_done),
        .o_status (res_status),
        .o_raw    (res_raw),
        .o_cd     (res_cd),
        .o_total  (cnt_total),
        .o_fail   (cnt_fail),
        .o_rate   (cnt_rate),
        .o_angle  (cnt_angle)
    );

    // port mapping
    assign full                = q_full;
    assign empty               = !res_valid;
    assign o_frame_done        = res_done;
    assign o_frame_status      = res_status;
    assign o_roll_sample       = res_raw[0];
    assign o_pitch_sample      = res_raw[1];
    assign o_yaw_sample        = res_raw[2];
    assign o_roll_centideg     = res_cd[0];
    assign o_pitch_centideg    = res_cd[1];
    assign o_yaw_centideg      = res_cd[2];
    assign o_total_bytes       = 32'(cnt_total);
    assign o_checksum_failures = 32'(cnt_fail);
    assign o_rate_frames       = 32'(cnt_rate);
    assign o_angle_frames      = 32'(cnt_angle);

    // every event taken from the queue shows up as a result next cycle
    a_rd_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |=> !empty)
        else $error("event read from queue did not reach result register");

    // the parser never writes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_wr && q_full))
        else $error("queue written while full");

    // failure count moves only with a shown bad-checksum result
    a_fail_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(cnt_fail)) |->
        (!empty && o_frame_done && (o_frame_status == ST_BADSUM)))
        else $error("checksum failure count changed without a bad frame");

    // angle frame count moves only with a shown good angle frame
    a_angle_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(cnt_angle)) |->
        (!empty && o_frame_done && (o_frame_status == ST_ANGLE)))
        else $error("angle frame count changed without an angle frame");

endmodule

### bench/imu_uart_frame_parser_check.sv
// imu_uart_frame_parser_check: result predictor and scoreboard for the frame parser
// watches both queue-style channels and compares every result transfer in order
// depends on imuf_pkg for status codes, frame byte codes and scaling constants
module imu_uart_frame_parser_check #(
    parameter int FRAME_BYTES = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_frame_done,
    input  logic [1:0]  i_frame_status,
    input  logic [15:0] i_roll_sample,
    input  logic [15:0] i_pitch_sample,
    input  logic [15:0] i_yaw_sample,
    input  logic [15:0] i_roll_centideg,
    input  logic [15:0] i_pitch_centideg,
    input  logic [15:0] i_yaw_centideg,
    input  logic [31:0] i_total_bytes,
    input  logic [31:0] i_checksum_failures,
    input  logic [31:0] i_rate_frames,
    input  logic [31:0] i_angle_frames,
    output int          o_mismatches,
    output int          o_waiting
);
    import imuf_pkg::*;

    // event counter slots
    localparam int CNT_BYTES  = 0;
    localparam int CNT_BADSUM = 1;
    localparam int CNT_RATE   = 2;
    localparam int CNT_ANGLE  = 3;

    typedef struct packed {
        logic                    done;
        t_status                 status;
        logic [N_AXES-1:0][15:0] raw;
        logic [N_AXES-1:0][15:0] centi;
        logic [3:0][31:0]        count;
    } t_frame_result;

    // parser state mirror
    logic [3:0]  frame_pos;
    logic [7:0]  run_sum;
    logic [7:0]  frame_kind;
    logic [7:0]  payload [PAY_BYTES];
    logic [15:0] angle_raw [N_AXES];
    logic [31:0] event_count [4];

    t_frame_result pending_results [$];
    int            mismatch_count;
    int            result_index;

    assign o_mismatches = mismatch_count;

    task automatic clear_parser();
        frame_pos  = '0;
        run_sum    = '0;
        frame_kind = '0;
        for (int i = 0; i < PAY_BYTES; i++) payload[i] = '0;
        for (int i = 0; i < N_AXES; i++) angle_raw[i] = '0;
        for (int i = 0; i < 4; i++) event_count[i] = '0;
    endtask

    // advance the parser by one byte and queue the result it yields
    task automatic decode_byte(input logic [7:0] b);
        t_frame_result r;
        int            signed_raw;
        r = '0;
        event_count[CNT_BYTES] = event_count[CNT_BYTES] + 1;
        r.done   = 1'b0;
        r.status = ST_ANGLE;
        if (frame_pos == 4'd0) begin
            if (b == HDR_BYTE) begin
                run_sum   = HDR_BYTE;
                frame_pos = 4'd1;
            end
        end else if (frame_pos == 4'd1) begin
            if (b == TYPE_ACC || b == TYPE_RATE || b == TYPE_ANGLE) begin
                frame_kind = b;
                run_sum    = run_sum + b;
                frame_pos  = 4'd2;
            end else if (b == HDR_BYTE) begin
                // bad type that is itself a header restarts the frame
                run_sum   = HDR_BYTE;
                frame_pos = 4'd1;
            end else begin
                frame_pos = 4'd0;
            end
        end else if (frame_pos >= FRAME_BYTES - 1) begin
            // checksum byte closes the frame
            r.done = 1'b1;
            if (run_sum != b) begin
                r.status = ST_BADSUM;
                event_count[CNT_BADSUM] = event_count[CNT_BADSUM] + 1;
            end else if (frame_kind == TYPE_RATE) begin
                r.status = ST_RATE;
                event_count[CNT_RATE] = event_count[CNT_RATE] + 1;
            end else if (frame_kind == TYPE_ANGLE) begin
                r.status = ST_ANGLE;
                for (int i = 0; i < N_AXES; i++)
                    angle_raw[i] = {payload[2*i+1], payload[2*i]};
                event_count[CNT_ANGLE] = event_count[CNT_ANGLE] + 1;
            end else begin
                r.status = ST_OTHER;
            end
            frame_pos = 4'd0;
        end else begin
            if (frame_pos >= 4'd2 && frame_pos <= 4'd7) payload[frame_pos - 4'd2] = b;
            run_sum   = run_sum + b;
            frame_pos = frame_pos + 4'd1;
        end
        for (int i = 0; i < N_AXES; i++) begin
            r.raw[i]   = angle_raw[i];
            signed_raw = $signed(angle_raw[i]);
            // integer division truncates toward zero
            r.centi[i] = 16'((signed_raw * CD_SCALE) / (2 ** CD_SHIFT));
        end
        for (int i = 0; i < 4; i++) r.count[i] = event_count[i];
        pending_results.push_back(r);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatch_count < 10)
                $display("mismatch on %s, result %0d: expected 0x%0h, got 0x%0h",
                         field, result_index, want, got);
            mismatch_count++;
        end
    endtask

    initial begin
        clear_parser();
        mismatch_count = 0;
        result_index   = 0;
        o_waiting      = 0;
    end

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            clear_parser();
            pending_results.delete();
        end else begin
            if (i_push && !i_full) decode_byte(i_rx_byte);
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result transfer %0d arrived with nothing expected",
                                 result_index);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("frame_done", want.done, i_frame_done);
                    check_field("frame_status", want.status, i_frame_status);
                    check_field("roll_sample", want.raw[0], i_roll_sample);
                    check_field("pitch_sample", want.raw[1], i_pitch_sample);
                    check_field("yaw_sample", want.raw[2], i_yaw_sample);
                    check_field("roll_centideg", want.centi[0], i_roll_centideg);
                    check_field("pitch_centideg", want.centi[1], i_pitch_centideg);
                    check_field("yaw_centideg", want.centi[2], i_yaw_centideg);
                    check_field("total_bytes", want.count[CNT_BYTES], i_total_bytes);
                    check_field("checksum_failures", want.count[CNT_BADSUM],
                                i_checksum_failures);
                    check_field("rate_frames", want.count[CNT_RATE], i_rate_frames);
                    check_field("angle_frames", want.count[CNT_ANGLE], i_angle_frames);
                end
                result_index++;
            end
        end
        o_waiting = pending_results.size();
    end

endmodule

### bench/imu_uart_frame_parser_test.sv
// imu_uart_frame_parser_test: stimulus and verdict for the imu serial frame parser
// drives serial bytes (directed frames, random frames, noise) with random idling
// depends on imuf_pkg, imu_uart_frame_parser and imu_uart_frame_parser_check
module imu_uart_frame_parser_test;
    import imuf_pkg::*;

    localparam int FRAME_BYTES = 11;
    localparam int RANDOM_ITEMS = 1050;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        full;
    logic        empty;
    logic        frame_done;
    logic [1:0]  frame_status;
    logic signed [15:0] roll_sample, pitch_sample, yaw_sample;
    logic signed [15:0] roll_centideg, pitch_centideg, yaw_centideg;
    logic [31:0] total_bytes, checksum_failures, rate_frames, angle_frames;

    int mismatches;
    int waiting;
    int bytes_sent = 0;
    int cycle_count = 0;
    int stall_cycles = 0;
    bit send_quiet = 1'b0;

    imu_uart_frame_parser #(.FRAME_BYTES(FRAME_BYTES)) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_rx_byte           (rx_byte),
        .empty               (empty),
        .pop                 (pop),
        .o_frame_done        (frame_done),
        .o_frame_status      (frame_status),
        .o_roll_sample       (roll_sample),
        .o_pitch_sample      (pitch_sample),
        .o_yaw_sample        (yaw_sample),
        .o_roll_centideg     (roll_centideg),
        .o_pitch_centideg    (pitch_centideg),
        .o_yaw_centideg      (yaw_centideg),
        .o_total_bytes       (total_bytes),
        .o_checksum_failures (checksum_failures),
        .o_rate_frames       (rate_frames),
        .o_angle_frames      (angle_frames)
    );

    imu_uart_frame_parser_check #(.FRAME_BYTES(FRAME_BYTES)) u_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_push              (push),
        .i_full              (full),
        .i_rx_byte           (rx_byte),
        .i_empty             (empty),
        .i_pop               (pop),
        .i_frame_done        (frame_done),
        .i_frame_status      (frame_status),
        .i_roll_sample       (roll_sample),
        .i_pitch_sample      (pitch_sample),
        .i_yaw_sample        (yaw_sample),
        .i_roll_centideg     (roll_centideg),
        .i_pitch_centideg    (pitch_centideg),
        .i_yaw_centideg      (yaw_centideg),
        .i_total_bytes       (total_bytes),
        .i_checksum_failures (checksum_failures),
        .i_rate_frames       (rate_frames),
        .i_angle_frames      (angle_frames),
        .o_mismatches        (mismatches),
        .o_waiting           (waiting)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: random pop with a quiet window of steady draining
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= 600 && cycle_count < 900)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(99) >= 18);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while (!send_quiet && $urandom_range(99) < 18) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    // full frame: header, type, three angles, two filler bytes, checksum
    task automatic send_frame(input logic [7:0] kind, input logic [15:0] roll,
                              input logic [15:0] pitch, input logic [15:0] yaw,
                              input logic [15:0] tail, input bit bad_sum);
        logic [7:0] body [10];
        logic [7:0] sum;
        body = '{HDR_BYTE, kind, roll[7:0], roll[15:8], pitch[7:0], pitch[15:8],
                 yaw[7:0], yaw[15:8], tail[7:0], tail[15:8]};
        sum = '0;
        for (int i = 0; i < 10; i++) begin
            sum = sum + body[i];
            send_byte(body[i]);
        end
        if (bad_sum) sum = sum ^ 8'($urandom_range(255, 1));
        send_byte(sum);
    endtask

    // sender holds off until every expected result is back
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0001;
            4: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_kind();
        case ($urandom_range(2))
            0: return TYPE_ACC;
            1: return TYPE_RATE;
            default: return TYPE_ANGLE;
        endcase
    endfunction

    initial begin
        int choice;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: byte extremes, bad types, header as bad type, extreme angles
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(HDR_BYTE);
        send_byte(8'h20);
        send_byte(HDR_BYTE);
        send_frame(TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 1'b0);
        send_frame(TYPE_RATE, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b1);
        drain_results();

        // random: mostly well-formed frames, the rest noise and broken frames
        while (bytes_sent < RANDOM_ITEMS) begin
            send_quiet = (bytes_sent >= 300 && bytes_sent < 500);
            if (bytes_sent >= 650 && bytes_sent < 662) drain_results();
            choice = $urandom_range(99);
            if (choice < 65) begin
                send_frame(pick_kind(), pick_angle(), pick_angle(), pick_angle(),
                           16'($urandom), 1'b0);
            end else if (choice < 77) begin
                send_frame(pick_kind(), pick_angle(), pick_angle(), pick_angle(),
                           16'($urandom), 1'b1);
            end else if (choice < 87) begin
                repeat ($urandom_range(4, 1))
                    send_byte(($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom));
            end else if (choice < 93) begin
                // header followed by an arbitrary type byte
                send_byte(HDR_BYTE);
                send_byte(8'($urandom));
            end else begin
                // truncated frame, the next header lands inside it
                send_byte(HDR_BYTE);
                send_byte(pick_kind());
                repeat ($urandom_range(6)) send_byte(8'($urandom));
            end
        end
        send_quiet = 1'b0;
        push <= 1'b0;

        // wait for the last results, then the pipeline latency
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
